// ----- hw/rtl/fhti_pkg.sv -----
// ----------------------------------------------------------------------------
// fhti_pkg
// Shared widths, codes and types for the fold-hash table insert block.
// ----------------------------------------------------------------------------
package fhti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int KEY_W       = 44;
    localparam int DIG_W       = 4;
    localparam int NUM_DIGITS  = 11;
    localparam int SUM_W       = 11;
    localparam int STEP_W      = 7;
    localparam int YEAR_W      = 14;
    localparam int COLL_W      = SIZE_W;
    localparam int ENTRY_W     = KEY_W + 1;
    localparam int ITER_W      = $clog2(SUM_W);
    localparam int PERIOD_W    = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
    localparam logic [DIG_W-1:0]  DIGIT_MAX  = 4'd9;

    // Result outcome codes
    typedef enum logic [1:0] {
        OUT_INSERT = 2'd0,
        OUT_UPDATE = 2'd1,
        OUT_FULL   = 2'd2
    } outcome_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_STEP,
        ST_CHECK
    } state_t;

    // Values taken from the key at request time
    typedef struct packed {
        logic [SUM_W-1:0]  fold_sum;
        logic [STEP_W-1:0] step;
        logic [YEAR_W-1:0] year;
        logic [DIG_W-1:0]  course;
    } key_info_t;

    // Saturate a nibble to a decimal digit
    function automatic logic [DIG_W-1:0] sat_digit(input logic [DIG_W-1:0] nib);
        logic [DIG_W-1:0] d;
        d = (nib > DIGIT_MAX) ? DIGIT_MAX : nib;
        return d;
    endfunction

endpackage

// ----- hw/rtl/fhti_ram.sv -----
// ----------------------------------------------------------------------------
// fhti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/fhti_csub.sv -----
// ----------------------------------------------------------------------------
// fhti_csub
// Shared conditional subtract: reduce a value below twice the modulus.
// ----------------------------------------------------------------------------
module fhti_csub (
    input  logic [fhti_pkg::SIZE_W-1:0] value,
    input  logic [fhti_pkg::SIZE_W-1:0] modulus,
    output logic [fhti_pkg::SIZE_W-1:0] result
);
    import fhti_pkg::*;

    // Subtract the modulus once when the value reaches it
    always_comb
    begin
        if (value >= modulus)
        begin
            result = value - modulus;
        end
        else
        begin
            result = value;
        end
    end

endmodule

// ----- hw/rtl/fhti_digits.sv -----
// ----------------------------------------------------------------------------
// fhti_digits
// Key decoder: saturate BCD digits, form fold sum, probe step, year, course.
// ----------------------------------------------------------------------------
module fhti_digits (
    input  logic [fhti_pkg::KEY_W-1:0] key,
    output fhti_pkg::key_info_t        info
);
    import fhti_pkg::*;

    logic [DIG_W-1:0]  d [NUM_DIGITS];
    logic [STEP_W-1:0] raw_step;

    // Split the key, digit 0 in the top nibble
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d[i] = sat_digit(key[DIG_W*(NUM_DIGITS-1-i) +: DIG_W]);
        end
    end

    // Fold sum of the two three-digit groups
    assign info.fold_sum = SUM_W'(d[5]) * SUM_W'(100) + SUM_W'(d[6]) * SUM_W'(10)
                         + SUM_W'(d[10])
                         + SUM_W'(d[7]) * SUM_W'(100) + SUM_W'(d[8]) * SUM_W'(10)
                         + SUM_W'(d[9]);

    // Probe step, a zero step becomes one
    assign raw_step  = STEP_W'(d[5]) * STEP_W'(10) + STEP_W'(d[10]);
    assign info.step = (raw_step == '0) ? STEP_W'(1) : raw_step;

    // Year from the first four digits, course from digit four
    assign info.year = YEAR_W'(d[0]) * YEAR_W'(1000) + YEAR_W'(d[1]) * YEAR_W'(100)
                     + YEAR_W'(d[2]) * YEAR_W'(10) + YEAR_W'(d[3]);
    assign info.course = d[4];

endmodule

// ----- hw/rtl/fold_hash_table_insert.sv -----
// ----------------------------------------------------------------------------
// fold_hash_table_insert
// Open-addressing hash insert of BCD keys with a fold hash and digit step.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with key_digits while busy is low; the request is taken at
//   that clock edge. The block then works alone: it reduces the fold sum
//   modulo the table size, then the probe step, then probes the table slot
//   by slot. The result (slot, outcome, collisions, period, year,
//   course_digit) is shown for exactly one cycle with done high; it must be
//   taken then, since the receiver cannot hold it off.
//   Done follows P slot probes, P being 1 up to the table size; busy drops
//   in the done cycle, so a new request is taken only once the last one is
//   done: the conditional subtractor and the single-read key RAM are shared.
//   table_size is to be written through cfg_we / cfg_data only while the
//   block is idle; the block itself does not enforce this. 0 acts as 1 and
//   values above the table depth act as the depth. After reset the block
//   clears the valid map, one slot a cycle, with busy high; configuration
//   writes are taken meanwhile.
// ----------------------------------------------------------------------------
module fold_hash_table_insert (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fhti_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [fhti_pkg::KEY_W-1:0]    key_digits,
    output logic                          done,
    output logic [fhti_pkg::SLOT_W-1:0]   slot,
    output logic [1:0]                    outcome,
    output logic [fhti_pkg::COLL_W-1:0]   collisions,
    output logic [fhti_pkg::PERIOD_W-1:0] period,
    output logic [fhti_pkg::YEAR_W-1:0]   year,
    output logic [fhti_pkg::DIG_W-1:0]    course_digit
);
    import fhti_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   eff_size;
    key_info_t           info;

    logic [KEY_W-1:0]    key_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [DIG_W-1:0]    course_reg;
    logic [SUM_W-1:0]    div_reg, div_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [SLOT_W-1:0]   stepm_reg, stepm_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   alt_reg, alt_next;
    logic [COLL_W-1:0]   coll_reg, coll_next;
    logic [SLOT_W-1:0]   clr_reg;

    logic                done_reg, done_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    outcome_t            outcome_reg, outcome_next;
    logic [COLL_W-1:0]   res_coll_reg, res_coll_next;

    logic [SIZE_W-1:0]   csub_in, csub_out;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic                accept;
    logic                iter_last;
    logic                slot_empty, slot_match, table_full, probe_end;
    logic [COLL_W-1:0]   coll_inc;
    logic [SLOT_W-1:0]   full_pos;

    // Submodules
    fhti_digits u_digits (
        .key  (key_digits),
        .info (info)
    );

    fhti_csub u_csub (
        .value   (csub_in),
        .modulus (eff_size),
        .result  (csub_out)
    );

    fhti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the configured size to the usable range
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_reg > SIZE_RESET)
        begin
            eff_size = SIZE_RESET;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign iter_last = (iter_reg == ITER_W'(SUM_W - 1));

    // Probe decode on the slot just read
    assign slot_empty = !ram_rdata[KEY_W];
    assign slot_match = ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == key_reg);
    assign coll_inc   = coll_reg + COLL_W'(1);
    assign table_full = !slot_empty && !slot_match && (coll_inc == eff_size);
    assign probe_end  = slot_empty || slot_match || table_full;
    assign full_pos   = (coll_reg == '0) ? csub_out[SLOT_W-1:0] : alt_reg;

    // Shared unit input: remainder shift step or next probe position
    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            csub_in = {1'b0, pos_reg} + {1'b0, stepm_reg};
        end
        else
        begin
            csub_in = {rem_reg[SIZE_W-2:0], div_reg[SUM_W-1]};
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SLOT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (iter_last)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (iter_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (probe_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        div_next      = div_reg;
        rem_next      = rem_reg;
        iter_next     = iter_reg;
        stepm_next    = stepm_reg;
        pos_next      = pos_reg;
        alt_next      = alt_reg;
        coll_next     = coll_reg;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        outcome_next  = outcome_reg;
        res_coll_next = res_coll_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = {1'b1, key_reg};
        ram_raddr     = pos_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    div_next  = info.fold_sum;
                    rem_next  = '0;
                    iter_next = '0;
                end
            end
            ST_HASH:
            begin
                rem_next  = csub_out;
                div_next  = {div_reg[SUM_W-2:0], 1'b0};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_last)
                begin
                    pos_next  = csub_out[SLOT_W-1:0];
                    div_next  = SUM_W'(step_reg);
                    rem_next  = '0;
                    iter_next = '0;
                end
            end
            ST_STEP:
            begin
                rem_next  = csub_out;
                div_next  = {div_reg[SUM_W-2:0], 1'b0};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_last)
                begin
                    stepm_next = csub_out[SLOT_W-1:0];
                    coll_next  = '0;
                end
            end
            ST_CHECK:
            begin
                if (coll_reg == '0)
                begin
                    alt_next = csub_out[SLOT_W-1:0];
                end
                if (slot_empty)
                begin
                    ram_we       = 1'b1;
                    done_next    = 1'b1;
                    slot_next    = pos_reg;
                    outcome_next = OUT_INSERT;
                end
                else if (slot_match)
                begin
                    done_next    = 1'b1;
                    slot_next    = pos_reg;
                    outcome_next = OUT_UPDATE;
                end
                else if (table_full)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = full_pos;
                    done_next    = 1'b1;
                    slot_next    = full_pos;
                    outcome_next = OUT_FULL;
                end
                else
                begin
                    // Advance to the next probe and read it now
                    pos_next  = csub_out[SLOT_W-1:0];
                    ram_raddr = csub_out[SLOT_W-1:0];
                end
                res_coll_next = slot_match || slot_empty ? coll_reg : coll_inc;
                coll_next     = coll_inc;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            size_reg  <= SIZE_RESET;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= key_digits;
            step_reg   <= info.step;
            year_reg   <= info.year;
            course_reg <= info.course;
        end
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        iter_reg     <= iter_next;
        stepm_reg    <= stepm_next;
        pos_reg      <= pos_next;
        alt_reg      <= alt_next;
        coll_reg     <= coll_next;
        slot_reg     <= slot_next;
        outcome_reg  <= outcome_next;
        res_coll_reg <= res_coll_next;
    end

    // Result ports
    assign done         = done_reg;
    assign slot         = slot_reg;
    assign outcome      = outcome_reg;
    assign collisions   = res_coll_reg;
    assign period       = PERIOD_W'(slot_reg[2:0]) + PERIOD_W'(1);
    assign year         = year_reg;
    assign course_digit = course_reg;

    // Checks
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, slot} < eff_size))
        else $error("result slot beyond table size");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (outcome_reg == OUT_FULL) |-> (collisions == eff_size))
        else $error("full-table result without a full walk");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> ({1'b0, pos_reg} < eff_size))
        else $error("probe position beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken without going busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule

// ----- sim/fhti_insert_compare.sv -----
// ----------------------------------------------------------------------------
// fhti_insert_compare
// Watches the request, configuration and result ports of the fold-hash
// table insert block. Keeps its own copy of the slot table and table size,
// works out the expected slot, outcome, collision count and key fields for
// every accepted request, and compares each result with the oldest one.
// ----------------------------------------------------------------------------
module fhti_insert_compare (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fhti_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          start,
    input  logic                          busy,
    input  logic [fhti_pkg::KEY_W-1:0]    key_digits,
    input  logic                          done,
    input  logic [fhti_pkg::SLOT_W-1:0]   slot,
    input  logic [1:0]                    outcome,
    input  logic [fhti_pkg::COLL_W-1:0]   collisions,
    input  logic [fhti_pkg::PERIOD_W-1:0] period,
    input  logic [fhti_pkg::YEAR_W-1:0]   year,
    input  logic [fhti_pkg::DIG_W-1:0]    course_digit,
    output int                            fail_count,
    output int                            pending,
    output int                            inserts,
    output int                            updates,
    output int                            overwrites
);
    import fhti_pkg::*;

    localparam int MAX_REPORTS = 40;

    // One expected result of an insert request
    typedef struct {
        logic [SLOT_W-1:0]   slot;
        outcome_t            outcome;
        logic [COLL_W-1:0]   coll;
        logic [PERIOD_W-1:0] period;
        logic [YEAR_W-1:0]   year;
        logic [DIG_W-1:0]    course;
    } insert_result_t;

    logic [KEY_W-1:0]  tbl_key   [0:TABLE_DEPTH-1];
    bit                tbl_valid [0:TABLE_DEPTH-1];
    logic [SIZE_W-1:0] size_reg;
    insert_result_t    insert_results [$];
    insert_result_t    want;
    int                fail_total;
    int                n_insert;
    int                n_update;
    int                n_overwrite;

    assign fail_count = fail_total;
    assign inserts    = n_insert;
    assign updates    = n_update;
    assign overwrites = n_overwrite;

    initial
    begin
        fail_total  = 0;
        n_insert    = 0;
        n_update    = 0;
        n_overwrite = 0;
    end

    // Walk the probe sequence of one key and update the slot table
    function automatic insert_result_t predict_insert(input logic [KEY_W-1:0] k);
        insert_result_t r;
        int unsigned    d [NUM_DIGITS];
        int unsigned    s;
        int unsigned    home;
        int unsigned    step;
        int unsigned    pos;
        int unsigned    tries;
        int unsigned    coll;
        bit             found;
        logic [3:0]     nib;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            nib  = k[4*(10-i) +: 4];
            d[i] = (nib > 4'd9) ? 9 : nib;
        end
        // zero acts as one slot, anything above the depth as the full depth
        if (size_reg == 0)
            s = 1;
        else if (size_reg > TABLE_DEPTH)
            s = TABLE_DEPTH;
        else
            s = size_reg;
        home = ((d[5]*100 + d[6]*10 + d[10]) + (d[7]*100 + d[8]*10 + d[9])) % s;
        step = d[5]*10 + d[10];
        if (step == 0)
            step = 1;
        pos   = home;
        tries = 0;
        coll  = 0;
        found = 1'b0;
        while (tbl_valid[pos] && tries < s && !found)
        begin
            if (tbl_key[pos] == k)
                found = 1'b1;
            else
            begin
                coll++;
                tries++;
                pos = (home + step * tries) % s;
            end
        end
        if (found)
            r.outcome = OUT_UPDATE;
        else if (!tbl_valid[pos])
        begin
            tbl_key[pos]   = k;
            tbl_valid[pos] = 1'b1;
            r.outcome      = OUT_INSERT;
        end
        else
        begin
            // every probe hit a foreign key: overwrite one step from home
            pos            = (home + step) % s;
            tbl_key[pos]   = k;
            tbl_valid[pos] = 1'b1;
            r.outcome      = OUT_FULL;
        end
        r.slot   = SLOT_W'(pos);
        r.coll   = COLL_W'(coll);
        r.period = PERIOD_W'(1 + pos % 8);
        r.year   = YEAR_W'(d[0]*1000 + d[1]*100 + d[2]*10 + d[3]);
        r.course = DIG_W'(d[4]);
        return r;
    endfunction

    // Flag one field that differs from its expected value
    task automatic check_field(input string what, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            if (fail_total < MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
            fail_total++;
        end
    endtask

    // Retire results, track the size register, predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TABLE_DEPTH; j++)
                tbl_valid[j] = 1'b0;
            size_reg = SIZE_RESET;
            insert_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (insert_results.size() == 0)
                begin
                    if (fail_total < MAX_REPORTS)
                        $display("%0t: result expected none actual slot %0d", $time, slot);
                    fail_total++;
                end
                else
                begin
                    want = insert_results.pop_front();
                    check_field("slot", 16'(want.slot), 16'(slot));
                    check_field("outcome", 16'(want.outcome), 16'(outcome));
                    check_field("collisions", 16'(want.coll), 16'(collisions));
                    check_field("period", 16'(want.period), 16'(period));
                    check_field("year", 16'(want.year), 16'(year));
                    check_field("course_digit", 16'(want.course), 16'(course_digit));
                end
            end
            if (cfg_we)
                size_reg = cfg_data;
            if (start && busy === 1'b0)
            begin
                want = predict_insert(key_digits);
                insert_results.push_back(want);
                case (want.outcome)
                    OUT_INSERT: n_insert++;
                    OUT_UPDATE: n_update++;
                    default:    n_overwrite++;
                endcase
            end
            pending <= insert_results.size();
        end
    end

endmodule

// ----- sim/tb_fold_hash_table_insert.sv -----
// ----------------------------------------------------------------------------
// tb_fold_hash_table_insert
// Drives BCD keys into the fold-hash table insert block over a range of table
// sizes (zero, one, small, the full depth and beyond it), with repeated keys
// for updates and crowded small tables for full-table overwrites. Results are
// checked by fhti_insert_compare; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_fold_hash_table_insert;

    import fhti_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 1100;
    localparam int NUM_PHASES     = 16;
    localparam int POOL_DEPTH     = 256;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [SIZE_W-1:0]   cfg_data   = '0;
    logic                start      = 1'b0;
    logic [KEY_W-1:0]    key_digits = '0;
    logic                busy;
    logic                done;
    logic [SLOT_W-1:0]   slot;
    logic [1:0]          outcome;
    logic [COLL_W-1:0]   collisions;
    logic [PERIOD_W-1:0] period;
    logic [YEAR_W-1:0]   year;
    logic [DIG_W-1:0]    course_digit;

    int fail_count;
    int pending;
    int inserts;
    int updates;
    int overwrites;
    int idle_cycles = 0;
    int sent        = 0;
    bit quiet       = 1'b0;

    // table size and request count of each random phase
    int phase_size  [0:NUM_PHASES-1] = '{1, 3, 8, 13, 37, 64, 100, 0,
                                        250, 1024, 2047, 5, 128, 1500, 20, 1024};
    int phase_items [0:NUM_PHASES-1] = '{40, 60, 80, 80, 100, 100, 100, 30,
                                        100, 60, 40, 50, 80, 40, 70, 20};

    logic [KEY_W-1:0] key_pool [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fold_hash_table_insert DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .key_digits   (key_digits),
        .done         (done),
        .slot         (slot),
        .outcome      (outcome),
        .collisions   (collisions),
        .period       (period),
        .year         (year),
        .course_digit (course_digit)
    );

    fhti_insert_compare u_compare (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .key_digits   (key_digits),
        .done         (done),
        .slot         (slot),
        .outcome      (outcome),
        .collisions   (collisions),
        .period       (period),
        .year         (year),
        .course_digit (course_digit),
        .fail_count   (fail_count),
        .pending      (pending),
        .inserts      (inserts),
        .updates      (updates),
        .overwrites   (overwrites)
    );

    // Abort when no request and no result moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("fold_hash_table_insert: mismatch");
                $finish;
            end
        end
    end

    // Mostly decimal digits, now and then a nibble above nine
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                k[4*i +: 4] = 4'($urandom_range(0, 15));
            else
                k[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return k;
    endfunction

    // Hold the request until the block takes it
    task automatic send_key(input logic [KEY_W-1:0] k);
        start      <= 1'b1;
        key_digits <= k;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sent++;
        key_pool.push_back(k);
        if (key_pool.size() > POOL_DEPTH)
            void'(key_pool.pop_front());
    endtask

    // Drop start for a random burst, sometimes only once the block is free
    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                @(posedge clk);
                while (busy !== 1'b0)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // Wait until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_table_size(input int v);
        cfg_we   <= 1'b1;
        cfg_data <= SIZE_W'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_directed(input logic [KEY_W-1:0] k);
        send_key(k);
        idle_gap();
    endtask

    initial
    begin
        logic [KEY_W-1:0] k;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset size: zero key (zero step), all nines, all nibbles saturated, update
        send_directed(44'h00000000000);
        send_directed(44'h99999999999);
        send_directed(44'hFFFFFFFFFFF);
        send_directed(44'h00000000000);
        drain();

        // size zero acts as one slot: update, a full overwrite, then an update
        set_table_size(0);
        send_directed(44'h00000000000);
        send_directed(44'h20241234567);
        send_directed(44'h20241234567);
        drain();
        set_table_size(1);
        send_directed(44'h00000000000);
        drain();

        // above the depth: zero step with busy digits, non-decimal hash digit
        set_table_size(2047);
        send_directed(44'h12345678901);
        send_directed(44'h19991099990);
        send_directed(44'h0000050000A);
        drain();

        // two slots: one insert, then full-table overwrites, the last for a key sent before
        set_table_size(2);
        send_directed(44'h11111111111);
        send_directed(44'h22222222222);
        send_directed(44'h33333333333);
        send_directed(44'h11111111111);
        drain();
        set_table_size(1024);
        send_directed(44'h19990000000);
        drain();

        // random phases, the last two with no idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            set_table_size(phase_size[p]);
            quiet = (p >= NUM_PHASES - 2) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if (key_pool.size() > 0 && $urandom_range(0, 3) == 0)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else
                    k = random_key();
                send_key(k);
                idle_gap();
            end
        end

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d requests over %0d table size settings (0 and 2047 included)",
                 sent, NUM_PHASES + 6);
        $display("outcomes: %0d inserts, %0d updates, %0d full-table overwrites",
                 inserts, updates, overwrites);
        if (fail_count == 0 && pending == 0)
            $display("fold_hash_table_insert: match");
        else
            $display("fold_hash_table_insert: mismatch");
        $finish;
    end

endmodule
